/* src/modified_utf8_canonicalizer_macros.svh */
// Assertion macros shared by the canonicalizer RTL.
`ifndef MODIFIED_UTF8_CANONICALIZER_MACROS_SVH
`define MODIFIED_UTF8_CANONICALIZER_MACROS_SVH

// same-cycle implication, disabled in reset
`define MU8C_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define MU8C_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/mu8c_pkg.sv */
// Shared types and constants of the modified UTF-8 canonicalizer.
package mu8c_pkg;

  localparam logic [16:0] LEN_CAP = 17'd65535;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  typedef struct packed {
    logic        err;
    logic        done;
    logic [1:0]  nbytes;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [15:0] len;
  } job_t;

endpackage

/* src/mu8c_front.sv */
// Front end: decode each input byte and build one job record of results.
module mu8c_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       in_byte,
  input  logic             fin,
  output mu8c_pkg::job_t   job,
  output logic             has_result
);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;
  localparam logic [1:0] PH_DROP   = 2'd3;

  logic [1:0]  phase_r, phase_nxt;
  logic        lit_r, lit_nxt;
  logic [10:0] pc_r, pc_nxt;
  logic [15:0] held_r, held_nxt;
  logic [15:0] cnt_r, cnt_nxt;

  logic        emit, fail, over, cont_ok;
  logic [1:0]  ecnt;
  logic [7:0]  e0, e1, e2;
  logic [10:0] code2;
  logic [15:0] code3;
  logic [16:0] sum;

  always_comb begin
    phase_nxt = phase_r;
    lit_nxt   = lit_r;
    pc_nxt    = pc_r;
    held_nxt  = held_r;
    cnt_nxt   = cnt_r;
    emit      = 1'b0;
    fail      = 1'b0;
    ecnt      = 2'd0;
    e0        = 8'h00;
    e1        = 8'h00;
    e2        = 8'h00;
    code2     = {pc_r[4:0], in_byte[5:0]};
    code3     = {pc_r[9:0], in_byte[5:0]};
    cont_ok   = (in_byte[7:6] == 2'b10);
    job       = '0;
    unique case (phase_r)
      PH_IDLE: begin
        if (in_byte != 8'h00 && !in_byte[7]) begin
          emit = 1'b1;
          ecnt = 2'd1;
          e0   = in_byte;
        end else if (in_byte == 8'h00 || !in_byte[6] || in_byte[7:4] == 4'hF || fin) begin
          fail = 1'b1;
        end else begin
          lit_nxt   = in_byte[5];
          pc_nxt    = {6'd0, in_byte[4:0]};
          held_nxt  = {in_byte, 8'h00};
          phase_nxt = PH_SECOND;
        end
      end
      PH_SECOND: begin
        if (!cont_ok) begin
          fail = 1'b1;
        end else if (lit_r) begin
          if (fin) begin
            fail = 1'b1;
          end else begin
            pc_nxt    = code2;
            held_nxt  = {held_r[15:8], in_byte};
            phase_nxt = PH_THIRD;
          end
        end else if (code2 != 11'd0 && code2 < 11'h080) begin
          emit = 1'b1;
          ecnt = 2'd1;
          e0   = code2[7:0];
        end else begin
          emit = 1'b1;
          ecnt = 2'd2;
          e0   = held_r[15:8];
          e1   = in_byte;
        end
      end
      PH_THIRD: begin
        if (!cont_ok) begin
          fail = 1'b1;
        end else if (code3 != 16'd0 && code3 < 16'h0080) begin
          emit = 1'b1;
          ecnt = 2'd1;
          e0   = code3[7:0];
        end else if (code3 < 16'h0800) begin
          emit = 1'b1;
          ecnt = 2'd2;
          e0   = {3'b110, code3[10:6]};
          e1   = {2'b10, code3[5:0]};
        end else begin
          emit = 1'b1;
          ecnt = 2'd3;
          e0   = held_r[15:8];
          e1   = held_r[7:0];
          e2   = in_byte;
        end
      end
      default: begin
        if (fin) begin
          phase_nxt = PH_IDLE;
        end
      end
    endcase

    sum  = {1'b0, cnt_r} + {15'd0, ecnt};
    over = emit && (sum > mu8c_pkg::LEN_CAP);

    if (fail || over) begin
      job.err   = 1'b1;
      cnt_nxt   = 16'd0;
      lit_nxt   = 1'b0;
      phase_nxt = fin ? PH_IDLE : PH_DROP;
    end else if (emit) begin
      job.nbytes = ecnt;
      job.b0     = e0;
      job.b1     = e1;
      job.b2     = e2;
      job.done   = fin;
      job.len    = sum[15:0];
      cnt_nxt    = fin ? 16'd0 : sum[15:0];
      lit_nxt    = 1'b0;
      phase_nxt  = PH_IDLE;
    end
    has_result = fail || emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      lit_r   <= 1'b0;
      cnt_r   <= 16'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      lit_r   <= lit_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pc_r   <= pc_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

/* src/mu8c_fifo.sv */
// Short job queue between the decoder and the result serializer.
module mu8c_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mu8c_pkg::job_t push_job,
  input  logic           pop,
  output mu8c_pkg::job_t head,
  output logic           head_valid,
  output logic           full
);

  mu8c_pkg::job_t                 mem_r [mu8c_pkg::QDEPTH];
  logic [mu8c_pkg::QPTR_W-1:0]    wr_r, wr_nxt, rd_r, rd_nxt;
  logic [mu8c_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;

  assign head       = mem_r[rd_r];
  assign head_valid = (cnt_r != '0);
  assign full       = (cnt_r == mu8c_pkg::QCNT_W'(mu8c_pkg::QDEPTH));

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == mu8c_pkg::QPTR_W'(mu8c_pkg::QDEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == mu8c_pkg::QPTR_W'(mu8c_pkg::QDEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_job;
    end
  end

endmodule

/* src/mu8c_back.sv */
// Back end: walk the head job and drive one result per cycle, unless stalled, into the output register.
module mu8c_back (
  input  logic           clk,
  input  logic           rst_n,
  input  mu8c_pkg::job_t head,
  input  logic           head_valid,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     out_kind,
  output logic [7:0]     out_byte,
  output logic [15:0]    out_len,
  output logic           out_last
);

  logic [1:0]  idx_r, idx_nxt;
  logic        ov_r, ov_nxt;
  logic [1:0]  kind_r, kind_c;
  logic [7:0]  byte_r, byte_c;
  logic [15:0] len_r, len_c;
  logic        last_r, last_c;
  logic [2:0]  total;
  logic        load;

  always_comb begin
    total = {1'b0, head.nbytes} + {2'd0, head.done};
    if (head.err) begin
      kind_c = mu8c_pkg::KIND_ERR;
      last_c = 1'b1;
    end else begin
      kind_c = (idx_r < head.nbytes) ? mu8c_pkg::KIND_DATA : mu8c_pkg::KIND_DONE;
      last_c = ({1'b0, idx_r} == total - 3'd1);
    end
    byte_c = 8'h00;
    if (kind_c == mu8c_pkg::KIND_DATA) begin
      unique case (idx_r)
        2'd0:    byte_c = head.b0;
        2'd1:    byte_c = head.b1;
        default: byte_c = head.b2;
      endcase
    end
    len_c   = (kind_c == mu8c_pkg::KIND_DONE) ? head.len : 16'd0;
    load    = head_valid && (!ov_r || out_ready);
    pop     = load && last_c;
    idx_nxt = pop ? 2'd0 : (load ? idx_r + 2'd1 : idx_r);
    ov_nxt  = load ? 1'b1 : (out_ready ? 1'b0 : ov_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
      ov_r  <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= kind_c;
      byte_r <= byte_c;
      len_r  <= len_c;
      last_r <= last_c;
    end
  end

  assign out_valid = ov_r;
  assign out_kind  = kind_r;
  assign out_byte  = byte_r;
  assign out_len   = len_r;
  assign out_last  = last_r;

endmodule

/* src/modified_utf8_canonicalizer.sv */
// Top level of the modified UTF-8 canonicalizer.
// Takes one byte of a modified UTF-8 string per cycle while in_tready is high (in_tlast on
// the last byte) and gives canonical bytes, then a done result with the output length, or
// one error result for a malformed or over-long string, after which input is dropped up to
// the last byte. The decoder takes a byte every cycle that in_tready allows and writes its
// results as one job into a four-entry queue; the serializer behind it gives one result per
// cycle through the output register unless out_tready holds it, so a byte's first result
// passes the queue and then the output register. in_tready falls only while the queue is
// full, when results (up to four per byte) arrive faster than the output side drains them.
`include "modified_utf8_canonicalizer_macros.svh"

module modified_utf8_canonicalizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] out_byte, [23:8] result_length
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast
);

  mu8c_pkg::job_t f_job, q_head;
  logic           f_has, accept, push, pop, q_valid, q_full;
  logic [7:0]     o_byte;
  logic [15:0]    o_len;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign push      = accept && f_has;

  mu8c_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .in_byte    (in_tdata),
    .fin        (in_tlast),
    .job        (f_job),
    .has_result (f_has)
  );

  mu8c_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (f_job),
    .pop        (pop),
    .head       (q_head),
    .head_valid (q_valid),
    .full       (q_full)
  );

  mu8c_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .head_valid (q_valid),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_kind   (out_tuser),
    .out_byte   (o_byte),
    .out_len    (o_len),
    .out_last   (out_tlast)
  );

  assign out_tdata = {o_len, o_byte};

  `MU8C_ASSERT_NOW(a_err_last, out_tvalid && out_tuser == mu8c_pkg::KIND_ERR, out_tlast, "error result not last")
  `MU8C_ASSERT_NOW(a_done_last, out_tvalid && out_tuser == mu8c_pkg::KIND_DONE, out_tlast, "done result not last")
  `MU8C_ASSERT_NOW(a_no_overflow, push, !q_full, "job queue overflow")
  `MU8C_ASSERT_NOW(a_pop_valid, pop, q_valid, "pop from empty job queue")

endmodule
